>>> hdl/gtp_pkg.sv
// Shared types, constants and codes for the greedy tier partition planner.
package gtp_pkg;

  localparam int SW = 48;
  localparam int AW = 24;
  localparam int UW = 52;
  localparam int MAX_DISKS_DEF = 10;
  localparam int MAX_PARTS_DEF = 64;
  localparam int MAX_RESULTS = 53;

  localparam logic [AW-1:0] DEFAULT_ALIGN = AW'(2048);
  localparam logic [SW-1:0] DEFAULT_MINPART = SW'(2097152);

  localparam logic [1:0] REG_PARITY = 2'd0;
  localparam logic [1:0] REG_ALIGN = 2'd1;
  localparam logic [1:0] REG_MINPART = 2'd2;

  localparam logic [1:0] PARITY_DUAL = 2'd2;

  localparam logic KIND_PART = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_TOO_FEW = 3'd1,
    ST_TOO_MANY = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_PART_LIMIT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_TIER,
    S_DIV,
    S_MUL,
    S_EMIT,
    S_UPD,
    S_SUM
  } state_t;

  typedef struct packed {
    logic          clear;
    logic          load;
    logic          init;
    logic          sub;
    logic [SW-1:0] value;
    logic [AW-1:0] align;
    logic [SW-1:0] minp;
    logic [SW-1:0] part;
  } cell_cmd_t;

endpackage

>>> hdl/gtp_cell.sv
// One disk cell: sorted insertion slot, remaining room and active flag.
module gtp_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gtp_pkg::cell_cmd_t     cmd,
  input  logic                   prev_valid,
  input  logic                   prev_gt,
  input  logic [gtp_pkg::SW-1:0] prev_size,
  output logic                   valid,
  output logic                   gt,
  output logic [gtp_pkg::SW-1:0] size,
  output logic [gtp_pkg::SW-1:0] avail,
  output logic                   active,
  output logic                   err
);
  import gtp_pkg::*;

  logic          valid_r, valid_nxt;
  logic          active_r, active_nxt;
  logic [SW-1:0] size_r;
  logic [SW-1:0] avail_r;
  logic          first_free;
  logic [SW-1:0] after_align;
  logic [SW-1:0] after_sub;

  assign gt          = valid_r && (size_r > cmd.value);
  assign first_free  = !valid_r && prev_valid;
  assign after_align = size_r - SW'(cmd.align);
  assign after_sub   = avail_r - cmd.part;
  assign err         = valid_r && ((size_r < SW'(cmd.align)) || (after_align < cmd.minp));

  assign valid  = valid_r;
  assign size   = size_r;
  assign avail  = avail_r;
  assign active = active_r;

  always_comb begin
    valid_nxt  = valid_r;
    active_nxt = active_r;
    if (cmd.clear) begin
      valid_nxt  = 1'b0;
      active_nxt = 1'b0;
    end else if (cmd.load) begin
      if (prev_gt || gt || first_free) valid_nxt = 1'b1;
    end else if (cmd.init) begin
      active_nxt = valid_r;
    end else if (cmd.sub && active_r) begin
      active_nxt = (after_sub >= cmd.minp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (prev_gt) size_r <= prev_size;
      else if (gt || first_free) size_r <= cmd.value;
    end
    if (cmd.init) avail_r <= after_align;
    else if (cmd.sub && active_r) avail_r <= after_sub;
  end

endmodule

>>> hdl/gtp_rem.sv
// Bit-serial remainder unit: size modulo alignment, one bit per cycle.
module gtp_rem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [gtp_pkg::SW-1:0] dividend,
  input  logic [gtp_pkg::AW-1:0] divisor,
  output logic                   done,
  output logic [gtp_pkg::AW-1:0] rem
);
  import gtp_pkg::*;

  localparam int CW = $clog2(SW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] dvd_r;
  logic [AW-1:0] rem_r;
  logic [AW:0]   trial;
  logic [AW:0]   rem_nxt;
  logic [AW-1:0] dsr_r;

  assign trial   = {rem_r, dvd_r[SW-1]};
  assign rem_nxt = (trial >= {1'b0, dsr_r}) ? trial - {1'b0, dsr_r} : trial;
  assign done    = done_r;
  assign rem     = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(SW-1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SW-2:0], 1'b0};
      rem_r <= rem_nxt[AW-1:0];
    end
  end

endmodule

>>> hdl/greedy_tier_partition_planner.sv
// Top level of the greedy tier partition planner.
// Loading: one disk per cycle while in the load state, insertion sort along the cell chain.
// Planning: two passes (check, then emit); each tier waits on the bit-serial
// remainder unit and, when emitting records, steps through every disk slot.
// Records leave one per cycle at most.
// Reset (rst_n, synchronous, low) empties the chain and restores registers.
module greedy_tier_partition_planner #(
  parameter int MAX_DISKS = gtp_pkg::MAX_DISKS_DEF,
  parameter int MAX_PARTS = gtp_pkg::MAX_PARTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [gtp_pkg::SW-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [gtp_pkg::SW-1:0] in_disk_sectors,
  input  logic                   in_last_disk,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_record_kind,
  output logic [3:0]             out_disk_index,
  output logic [gtp_pkg::SW-1:0] out_offset_sectors,
  output logic [gtp_pkg::SW-1:0] out_size_sectors,
  output logic [3:0]             out_tier_index,
  output logic [4:0]             out_tier_members,
  output logic [gtp_pkg::UW-1:0] out_tier_usable,
  output logic [gtp_pkg::UW-1:0] out_total_raw,
  output logic [gtp_pkg::UW-1:0] out_total_usable,
  output logic [4:0]             out_tier_total,
  output logic [2:0]             out_status,
  output logic                   out_last
);
  import gtp_pkg::*;

  localparam int LCW = $clog2(MAX_DISKS + 1);
  localparam int IW = $clog2(MAX_DISKS);
  localparam int LIMIT = (MAX_PARTS < MAX_RESULTS - 1) ? MAX_PARTS : MAX_RESULTS - 1;
  localparam int PCW = $clog2(MAX_PARTS + MAX_DISKS + 1);

  // configuration
  logic [1:0]    par_r;
  logic [AW-1:0] align_r;
  logic [SW-1:0] minp_r;
  logic [AW-1:0] align_eff;
  logic [SW-1:0] minp_eff;
  logic [1:0]    par_eff;
  logic [LCW-1:0] need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r   <= 2'd1;
      align_r <= DEFAULT_ALIGN;
      minp_r  <= DEFAULT_MINPART;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PARITY:  par_r <= cfg_wdata[1:0];
        REG_ALIGN:   align_r <= cfg_wdata[AW-1:0];
        REG_MINPART: minp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign align_eff = (align_r == '0) ? DEFAULT_ALIGN : align_r;
  assign minp_eff  = (minp_r == '0) ? DEFAULT_MINPART : minp_r;
  assign par_eff   = (par_r == PARITY_DUAL) ? 2'd2 : 2'd1;
  assign need      = (par_r == PARITY_DUAL) ? LCW'(4) : LCW'(3);

  // state
  state_t         state_r, state_nxt;
  logic [LCW-1:0] loaded_r;
  logic           ovf_r;
  logic [UW-1:0]  raw_r;
  logic [UW-1:0]  usable_r;
  logic [3:0]     tier_r;
  logic [PCW-1:0] pcnt_r;
  logic           pass_r;
  status_t        status_r;
  logic [SW-1:0]  lo_r;
  logic [SW-1:0]  part_r;
  logic [LCW-1:0] members_r;
  logic [UW-1:0]  tusable_r;
  logic [SW-1:0]  offset_r;
  logic [IW-1:0]  idx_r;

  // cell chain
  cell_cmd_t     cmd;
  logic          c_valid  [MAX_DISKS];
  logic          c_gt     [MAX_DISKS];
  logic [SW-1:0] c_size   [MAX_DISKS];
  logic [SW-1:0] c_avail  [MAX_DISKS];
  logic          c_active [MAX_DISKS];
  logic          c_err    [MAX_DISKS];
  logic          p_valid  [MAX_DISKS];
  logic          p_gt     [MAX_DISKS];
  logic [SW-1:0] p_size   [MAX_DISKS];

  for (genvar g = 0; g < MAX_DISKS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign p_valid[g] = 1'b1;
      assign p_gt[g]    = 1'b0;
      assign p_size[g]  = '0;
    end else begin : g_link
      assign p_valid[g] = c_valid[g-1];
      assign p_gt[g]    = c_gt[g-1];
      assign p_size[g]  = c_size[g-1];
    end
    gtp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (p_valid[g]),
      .prev_gt    (p_gt[g]),
      .prev_size  (p_size[g]),
      .valid      (c_valid[g]),
      .gt         (c_gt[g]),
      .size       (c_size[g]),
      .avail      (c_avail[g]),
      .active     (c_active[g]),
      .err        (c_err[g])
    );
  end

  // remainder unit
  logic          rem_start;
  logic          rem_done;
  logic [AW-1:0] rem_val;

  gtp_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (lo_sel),
    .divisor  (align_eff),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // shared decode
  logic           out_valid_r;
  logic           slot_free;
  logic           in_fire;
  logic           any_err;
  status_t        chk_status;
  logic [LCW-1:0] act_cnt;
  logic [SW-1:0]  lo_sel;
  logic           tier_end;
  logic           part_small;
  logic           over_lim;
  logic           emit_act;
  logic           emit_adv;
  logic           emit_lastidx;
  logic [4:0]     mfac;
  logic [52:0]    prod;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    any_err = 1'b0;
    act_cnt = '0;
    lo_sel  = '0;
    for (int i = 0; i < MAX_DISKS; i++) begin
      any_err = any_err | c_err[i];
      act_cnt = act_cnt + LCW'(c_active[i]);
    end
    for (int i = MAX_DISKS - 1; i >= 0; i--) begin
      if (c_active[i]) lo_sel = c_avail[i];
    end
  end

  always_comb begin
    if (ovf_r) chk_status = ST_TOO_MANY;
    else if (loaded_r < need) chk_status = ST_TOO_FEW;
    else if (any_err) chk_status = ST_TOO_SMALL;
    else chk_status = ST_OK;
  end

  assign tier_end     = act_cnt < need;
  assign part_small   = part_r < minp_eff;
  assign over_lim     = !pass_r && ((pcnt_r + PCW'(members_r)) > PCW'(LIMIT));
  assign emit_act     = c_active[idx_r];
  assign emit_adv     = !emit_act || slot_free;
  assign emit_lastidx = (idx_r == IW'(MAX_DISKS - 1));
  assign mfac         = 5'(members_r) - 5'(par_eff);
  assign prod         = part_r * mfac;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (in_fire && in_last_disk) state_nxt = S_INIT;
      S_INIT: state_nxt = (chk_status != ST_OK) ? S_SUM : S_TIER;
      S_TIER: begin
        if (tier_end) state_nxt = pass_r ? S_SUM : S_INIT;
        else state_nxt = S_DIV;
      end
      S_DIV: if (rem_done) state_nxt = S_MUL;
      S_MUL: begin
        if (part_small) state_nxt = pass_r ? S_SUM : S_INIT;
        else if (over_lim) state_nxt = S_SUM;
        else state_nxt = pass_r ? S_EMIT : S_UPD;
      end
      S_EMIT: if (emit_adv && emit_lastidx) state_nxt = S_UPD;
      S_UPD: state_nxt = S_TIER;
      S_SUM: if (slot_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // control outputs
  logic rec_load;
  logic sum_load;

  always_comb begin
    cmd.clear = (state_r == S_SUM) && slot_free;
    cmd.load  = in_fire && (loaded_r < LCW'(MAX_DISKS));
    cmd.init  = (state_r == S_INIT);
    cmd.sub   = (state_r == S_UPD);
    cmd.value = in_disk_sectors;
    cmd.align = align_eff;
    cmd.minp  = minp_eff;
    cmd.part  = part_r;
    rem_start = (state_r == S_TIER) && !tier_end;
    rec_load  = (state_r == S_EMIT) && emit_act && slot_free;
    sum_load  = (state_r == S_SUM) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      loaded_r <= '0;
      ovf_r    <= 1'b0;
      raw_r    <= '0;
      usable_r <= '0;
      tier_r   <= '0;
      pcnt_r   <= '0;
      pass_r   <= 1'b0;
      status_r <= ST_OK;
      idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_LOAD: begin
          if (cmd.load) begin
            loaded_r <= loaded_r + 1'b1;
            raw_r    <= raw_r + UW'(in_disk_sectors);
          end else if (in_fire) begin
            ovf_r <= 1'b1;
          end
        end
        S_INIT: begin
          status_r <= chk_status;
          usable_r <= '0;
          tier_r   <= '0;
          pcnt_r   <= '0;
        end
        S_TIER: begin
          idx_r <= '0;
          if (tier_end && !pass_r) pass_r <= 1'b1;
        end
        S_MUL: begin
          if (part_small) begin
            if (!pass_r) pass_r <= 1'b1;
          end else if (over_lim) begin
            status_r <= ST_PART_LIMIT;
          end else if (!pass_r) begin
            pcnt_r <= pcnt_r + PCW'(members_r);
          end
        end
        S_EMIT: if (emit_adv && !emit_lastidx) idx_r <= idx_r + 1'b1;
        S_UPD: begin
          usable_r <= usable_r + tusable_r;
          tier_r   <= tier_r + 1'b1;
        end
        S_SUM: begin
          if (slot_free) begin
            loaded_r <= '0;
            ovf_r    <= 1'b0;
            raw_r    <= '0;
            pass_r   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_INIT) offset_r <= SW'(align_eff);
    if (state_r == S_UPD) offset_r <= offset_r + part_r;
    if (rem_start) begin
      lo_r      <= lo_sel;
      members_r <= act_cnt;
    end
    if ((state_r == S_DIV) && rem_done) part_r <= lo_r - SW'(rem_val);
    if (state_r == S_MUL) tusable_r <= prod[UW-1:0];
  end

  // result register
  logic          o_kind_r;
  logic [3:0]    o_disk_r;
  logic [SW-1:0] o_off_r;
  logic [SW-1:0] o_size_r;
  logic [3:0]    o_tier_r;
  logic [4:0]    o_memb_r;
  logic [UW-1:0] o_tus_r;
  logic [UW-1:0] o_raw_r;
  logic [UW-1:0] o_tot_r;
  logic [4:0]    o_ntier_r;
  logic [2:0]    o_stat_r;
  logic          o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_load || sum_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      o_kind_r  <= KIND_PART;
      o_disk_r  <= 4'(idx_r);
      o_off_r   <= offset_r;
      o_size_r  <= part_r;
      o_tier_r  <= tier_r;
      o_memb_r  <= 5'(members_r);
      o_tus_r   <= tusable_r;
      o_raw_r   <= '0;
      o_tot_r   <= '0;
      o_ntier_r <= '0;
      o_stat_r  <= ST_OK;
      o_last_r  <= 1'b0;
    end else if (sum_load) begin
      o_kind_r  <= KIND_SUMMARY;
      o_disk_r  <= '0;
      o_off_r   <= '0;
      o_size_r  <= '0;
      o_tier_r  <= '0;
      o_memb_r  <= '0;
      o_tus_r   <= '0;
      o_raw_r   <= raw_r;
      o_tot_r   <= (status_r == ST_OK) ? usable_r : '0;
      o_ntier_r <= (status_r == ST_OK) ? 5'(tier_r) : '0;
      o_stat_r  <= status_r;
      o_last_r  <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_kind    = o_kind_r;
  assign out_disk_index     = o_disk_r;
  assign out_offset_sectors = o_off_r;
  assign out_size_sectors   = o_size_r;
  assign out_tier_index     = o_tier_r;
  assign out_tier_members   = o_memb_r;
  assign out_tier_usable    = o_tus_r;
  assign out_total_raw      = o_raw_r;
  assign out_total_usable   = o_tot_r;
  assign out_tier_total     = o_ntier_r;
  assign out_status         = o_stat_r;
  assign out_last           = o_last_r;

endmodule

>>> tb/greedy_tier_partition_planner_tb.sv
// Testbench for the greedy tier partition planner: directed table, then random disk sets.
module greedy_tier_partition_planner_tb;
  import gtp_pkg::*;

  localparam int NDISK = 10;
  localparam int NPART = 64;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic          kind;
    logic [3:0]    disk;
    logic [SW-1:0] off;
    logic [SW-1:0] size;
    logic [3:0]    tier;
    logic [4:0]    members;
    logic [UW-1:0] tusable;
    logic [UW-1:0] raw;
    logic [UW-1:0] usable;
    logic [4:0]    ntiers;
    logic [2:0]    status;
    logic          last;
  } record_t;

  typedef struct {
    logic [SW-1:0] sectors;
    logic          last_disk;
    logic          has_want;
    status_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_PARITY;
  logic [SW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SW-1:0] in_disk_sectors = '0;
  logic in_last_disk = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_record_kind;
  logic [3:0] out_disk_index;
  logic [SW-1:0] out_offset_sectors, out_size_sectors;
  logic [3:0] out_tier_index;
  logic [4:0] out_tier_members;
  logic [UW-1:0] out_tier_usable, out_total_raw, out_total_usable;
  logic [4:0] out_tier_total;
  logic [2:0] out_status;
  logic out_last;

  greedy_tier_partition_planner dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // planner shadow
  logic [1:0] m_parity;
  logic [AW-1:0] m_align;
  logic [SW-1:0] m_minp;
  logic [SW-1:0] m_room [NDISK];
  logic [SW-1:0] m_next [NDISK];
  int m_loaded;
  bit m_over;
  logic [UW-1:0] m_raw;

  record_t plan_q[$];
  status_t want_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit sender_pause = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic void push_rec(input record_t r);
    plan_q.push_back(r);
  endfunction

  function automatic void plan_disk(input logic [SW-1:0] v, input logic lst);
    int pos, par, need, cnt, active, members, np;
    logic [SW-1:0] al, mp, lo, part, sz;
    logic [UW-1:0] tus, usum;
    logic [3:0] tc;
    logic [NDISK-1:0] mask;
    status_t st;
    record_t r, parts[$];
    if (m_loaded < NDISK) begin
      pos = m_loaded;
      while (pos > 0 && m_room[pos-1] > v) begin
        m_room[pos] = m_room[pos-1];
        pos--;
      end
      m_room[pos] = v;
      m_loaded++;
      m_raw = m_raw + UW'(v);
    end else m_over = 1;
    if (!lst) return;
    par = (m_parity == PARITY_DUAL) ? 2 : 1;
    need = par + 2;
    al = (m_align != 0) ? SW'(m_align) : SW'(DEFAULT_ALIGN);
    mp = (m_minp != 0) ? m_minp : DEFAULT_MINPART;
    cnt = m_loaded;
    usum = '0;
    tc = '0;
    np = 0;
    st = ST_OK;
    if (m_over) st = ST_TOO_MANY;
    else if (cnt < need) st = ST_TOO_FEW;
    else begin
      for (int i = 0; i < cnt; i++) begin
        if (m_room[i] < al) begin
          st = ST_TOO_SMALL;
          continue;
        end
        m_room[i] -= al;
        m_next[i] = al;
        if (m_room[i] < mp) st = ST_TOO_SMALL;
      end
    end
    if (st == ST_OK) begin
      mask = '0;
      for (int i = 0; i < cnt; i++) mask[i] = 1'b1;
      active = cnt;
      while (active >= need && st == ST_OK) begin
        lo = '1;
        members = active;
        for (int i = 0; i < cnt; i++)
          if (mask[i] && m_room[i] < lo) lo = m_room[i];
        part = lo - lo % al;
        if (part < mp) break;
        tus = UW'(part) * UW'(members - par);
        for (int i = 0; i < cnt; i++) begin
          if (!mask[i]) continue;
          sz = (m_room[i] < part) ? m_room[i] - m_room[i] % al : part;
          if (sz < mp) begin
            mask[i] = 1'b0;
            active--;
            continue;
          end
          if (np >= NPART || parts.size() >= MAX_RESULTS - 1) begin
            st = ST_PART_LIMIT;
            break;
          end
          r = '0;
          r.kind = KIND_PART;
          r.disk = 4'(i);
          r.off = m_next[i];
          r.size = sz;
          r.tier = tc;
          r.members = 5'(members);
          r.tusable = tus;
          parts.push_back(r);
          np++;
          m_next[i] = m_next[i] + sz;
          m_room[i] -= sz;
          if (m_room[i] < mp) begin
            mask[i] = 1'b0;
            active--;
          end
        end
        if (st != ST_OK) break;
        usum = usum + tus;
        tc = tc + 4'd1;
      end
    end
    if (st != ST_OK) begin
      parts.delete();
      usum = '0;
      tc = '0;
    end
    foreach (parts[k]) push_rec(parts[k]);
    r = '0;
    r.kind = KIND_SUMMARY;
    r.raw = m_raw;
    r.usable = usum;
    r.ntiers = 5'(tc);
    r.status = st;
    r.last = 1'b1;
    push_rec(r);
    m_loaded = 0;
    m_over = 0;
    m_raw = '0;
  endfunction

  // receiver with its own stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 7) < 5) || ($time / 4000) % 3 == 0;
  end

  // long hold-off, counted in receiver cycles once requested
  initial begin
    wait (hold_off);
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    record_t e;
    if (rst_n && out_valid && out_ready) begin
      if (plan_q.size() == 0) begin
        report("unexpected record", out_record_kind, 0);
      end else begin
        e = plan_q.pop_front();
        if (out_record_kind !== e.kind) report("record_kind", out_record_kind, e.kind);
        if (out_disk_index !== e.disk) report("disk_index", out_disk_index, e.disk);
        if (out_offset_sectors !== e.off) report("offset", out_offset_sectors, e.off);
        if (out_size_sectors !== e.size) report("size", out_size_sectors, e.size);
        if (out_tier_index !== e.tier) report("tier_index", out_tier_index, e.tier);
        if (out_tier_members !== e.members) report("members", out_tier_members, e.members);
        if (out_tier_usable !== e.tusable) report("tier_usable", out_tier_usable, e.tusable);
        if (out_total_raw !== e.raw) report("total_raw", out_total_raw, e.raw);
        if (out_total_usable !== e.usable) report("total_usable", out_total_usable, e.usable);
        if (out_tier_total !== e.ntiers) report("tier_total", out_tier_total, e.ntiers);
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_last !== e.last) report("last", out_last, e.last);
        if (e.kind == KIND_SUMMARY && want_q.size() > 0) begin
          if (out_status !== want_q[0]) report("directed status", out_status, want_q[0]);
          void'(want_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("greedy_tier_partition_planner_tb: errors");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [SW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PARITY: m_parity = val[1:0];
      REG_ALIGN: m_align = val[AW-1:0];
      default: m_minp = val;
    endcase
  endtask

  task automatic drain();
    while (plan_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  // optional random gap, then hold valid until the transfer
  task automatic send(input logic [SW-1:0] v, input logic lst, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_disk_sectors <= v;
    in_last_disk <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    plan_disk(v, lst);
  endtask

  function automatic logic [SW-1:0] rnd48();
    return SW'({$urandom, $urandom});
  endfunction

  // random disk size: mostly plausible, sometimes extreme
  function automatic logic [SW-1:0] rand_disk();
    case ($urandom_range(0, 9))
      0: return rnd48();
      1: return SW'($urandom_range(0, 5000));
      2: return {SW{1'b1}} - SW'($urandom_range(0, 100));
      default: return SW'($urandom_range(1, 40)) * 48'd1048576 + SW'($urandom_range(0, 9999));
    endcase
  endfunction

  row_t dir[$];

  task automatic add(input logic [SW-1:0] v, input logic l, input bit hw, input status_t w);
    row_t r;
    r.sectors = v;
    r.last_disk = l;
    r.has_want = hw;
    r.want = w;
    dir.push_back(r);
  endtask

  initial begin
    int nitems, nd;
    bit gaps;
    m_parity = 2'd1;
    m_align = DEFAULT_ALIGN;
    m_minp = DEFAULT_MINPART;
    m_loaded = 0;
    m_over = 0;
    m_raw = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add(48'd8000000, 1, 1, ST_TOO_FEW);
    add(48'd100, 0, 0, ST_OK);
    add(48'd9000000, 0, 0, ST_OK);
    add(48'd9000000, 1, 1, ST_TOO_SMALL);
    add({SW{1'b1}}, 0, 0, ST_OK);
    add(48'd0, 0, 0, ST_OK);
    add(48'd5000000, 1, 1, ST_TOO_SMALL);
    add(48'd8000000, 0, 0, ST_OK);
    add(48'd12000000, 0, 0, ST_OK);
    add(48'd30000000, 0, 0, ST_OK);
    add(48'd16000000, 1, 1, ST_OK);
    for (int i = 0; i < 11; i++) add(48'd4000000 + 48'(i), i == 10, i == 10, ST_TOO_MANY);
    foreach (dir[k]) begin
      send(dir[k].sectors, dir[k].last_disk, 0);
      if (dir[k].has_want) want_q.push_back(dir[k].want);
    end
    in_valid <= 1'b0;
    drain();

    // random phases over register settings
    nitems = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cfg_write(REG_PARITY, 2); cfg_write(REG_ALIGN, 0); cfg_write(REG_MINPART, 0); end
        1: begin cfg_write(REG_PARITY, 0); cfg_write(REG_ALIGN, 1); cfg_write(REG_MINPART, 1); end
        2: begin cfg_write(REG_PARITY, 3); cfg_write(REG_ALIGN, 48'hFFFFFF);
                 cfg_write(REG_MINPART, 48'd16777216); end
        3: begin cfg_write(REG_PARITY, 1); cfg_write(REG_ALIGN, 4096);
                 cfg_write(REG_MINPART, {SW{1'b1}}); end
        4: begin cfg_write(REG_PARITY, 2); cfg_write(REG_ALIGN, 512);
                 cfg_write(REG_MINPART, 48'd65536); end
        default: begin
          cfg_write(REG_PARITY, 48'($urandom_range(0, 3)));
          cfg_write(REG_ALIGN, 48'($urandom_range(0, 8192)));
          cfg_write(REG_MINPART, 48'($urandom_range(0, 4000000)));
        end
      endcase
      if (ph == 1) hold_off = 1;
      for (int s = 0; s < 10; s++) begin
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 13) : $urandom_range(3, 10);
        gaps = (s % 3) != 0;
        for (int d = 0; d < nd; d++) begin
          send(rand_disk(), d == nd - 1, gaps);
          nitems++;
        end
        if (s == 4) begin
          in_valid <= 1'b0;
          while (plan_q.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      drain();
      if (nitems > 370) break;
    end

    if (errors == 0 && plan_q.size() == 0) begin
      $display("greedy_tier_partition_planner_tb: clean");
    end else begin
      $display("greedy_tier_partition_planner_tb: errors");
    end
    $finish;
  end

endmodule
